### src/esv_pkg.sv
// Package for the exact version-pin validator.
// Parser state type, phase codes, character constants and the reset state.
// No dependencies.
`default_nettype none

package esv_pkg;

   localparam int CH_W = 8;

   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
   localparam logic [CH_W-1:0] CH_UC_Z  = 8'h5A;
   localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [CH_W-1:0] CH_LC_Z  = 8'h7A;

   localparam logic [1:0] LEN_MAX = 2'd3;

   localparam logic ACT_CHAR = 1'b0;
   localparam logic ACT_END  = 1'b1;

   typedef enum logic [2:0] {
      PH_MAJOR = 3'd0,
      PH_MINOR = 3'd1,
      PH_PATCH = 3'd2,
      PH_PRE   = 3'd3,
      PH_BUILD = 3'd4
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] ident_length;
      logic       first_is_zero;
      logic       ident_all_digits;
      logic       rejected;
      logic       suffix_seen;
   } state_type;

   function automatic state_type reset_state();
      state_type s;
      s.phase            = PH_MAJOR;
      s.ident_length     = 2'd0;
      s.first_is_zero    = 1'b0;
      s.ident_all_digits = 1'b1;
      s.rejected         = 1'b0;
      s.suffix_seen      = 1'b0;
      return s;
   endfunction

endpackage

`default_nettype wire

### src/esv_step.sv
// Next-state and verdict logic of the version-pin parser for one request.
// Purely combinational; uses esv_pkg.
`default_nettype none

module esv_step (
   input  wire esv_pkg::state_type state,
   input  wire                     action,
   input  wire [esv_pkg::CH_W-1:0] ch,
   output esv_pkg::state_type      state_next,
   output logic                    verdict
);

   logic is_digit;
   logic is_pre;
   logic pre_ok;
   esv_pkg::state_type taken;
   esv_pkg::state_type fresh;
   esv_pkg::state_type char_next;

   assign is_digit = (ch >= esv_pkg::CH_ZERO) && (ch <= esv_pkg::CH_NINE);
   assign is_pre   = is_digit || (ch == esv_pkg::CH_MINUS)
                  || ((ch >= esv_pkg::CH_LC_A) && (ch <= esv_pkg::CH_LC_Z))
                  || ((ch >= esv_pkg::CH_UC_A) && (ch <= esv_pkg::CH_UC_Z));
   assign pre_ok   = (state.ident_length != 2'd0)
                  && !(state.ident_all_digits && state.first_is_zero
                       && (state.ident_length >= 2'd2));

   // character appended to current identifier
   always_comb begin
      taken = state;
      if (state.ident_length == 2'd0) begin
         taken.first_is_zero = (ch == esv_pkg::CH_ZERO);
      end
      if (!is_digit) begin
         taken.ident_all_digits = 1'b0;
      end
      if (state.ident_length < esv_pkg::LEN_MAX) begin
         taken.ident_length = state.ident_length + 2'd1;
      end
   end

   // new identifier started, phase kept
   always_comb begin
      fresh                  = state;
      fresh.ident_length     = 2'd0;
      fresh.first_is_zero    = 1'b0;
      fresh.ident_all_digits = 1'b1;
   end

   always_comb begin
      char_next = state;
      if (!state.rejected) begin
         unique case (state.phase) inside
            esv_pkg::PH_MAJOR, esv_pkg::PH_MINOR, esv_pkg::PH_PATCH: begin
               if (is_digit) begin
                  if ((state.ident_length != 2'd0) && state.first_is_zero) begin
                     char_next.rejected = 1'b1;
                  end else begin
                     char_next = taken;
                  end
               end else if (ch == esv_pkg::CH_DOT) begin
                  if ((state.ident_length == 2'd0) || (state.phase == esv_pkg::PH_PATCH)) begin
                     char_next.rejected = 1'b1;
                  end else begin
                     char_next       = fresh;
                     char_next.phase = esv_pkg::phase_type'(state.phase + 3'd1);
                  end
               end else if ((ch == esv_pkg::CH_MINUS) || (ch == esv_pkg::CH_PLUS)) begin
                  if ((state.phase != esv_pkg::PH_PATCH) || (state.ident_length == 2'd0)) begin
                     char_next.rejected = 1'b1;
                  end else begin
                     char_next       = fresh;
                     char_next.phase = (ch == esv_pkg::CH_MINUS) ? esv_pkg::PH_PRE
                                                                 : esv_pkg::PH_BUILD;
                  end
               end else begin
                  char_next.rejected = 1'b1;
               end
            end
            esv_pkg::PH_PRE: begin
               if ((ch == esv_pkg::CH_DOT) || (ch == esv_pkg::CH_PLUS)) begin
                  if (!pre_ok) begin
                     char_next.rejected = 1'b1;
                  end else begin
                     char_next = fresh;
                     if (ch == esv_pkg::CH_PLUS) begin
                        char_next.phase = esv_pkg::PH_BUILD;
                     end
                  end
               end else if (is_pre) begin
                  char_next = taken;
               end else begin
                  char_next.rejected = 1'b1;
               end
            end
            esv_pkg::PH_BUILD: begin
               char_next.suffix_seen = 1'b1;
            end
            default: begin
               char_next.rejected = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      verdict = 1'b0;
      if (!state.rejected) begin
         unique case (state.phase)
            esv_pkg::PH_PATCH: verdict = (state.ident_length != 2'd0);
            esv_pkg::PH_PRE:   verdict = pre_ok;
            esv_pkg::PH_BUILD: verdict = state.suffix_seen;
            default:           verdict = 1'b0;
         endcase
      end
   end

   assign state_next = (action == esv_pkg::ACT_END) ? esv_pkg::reset_state() : char_next;

endmodule

`default_nettype wire

### src/exact_semver_validator.sv
// Top level of the exact version-pin validator: input register, parser state,
// result register. Uses esv_pkg and esv_step.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_action, req_ch
//   rsp     | out       | rsp_valid/rsp_stall | rsp_valid_res
//
// One request per clock sustained, except while an end-of-string request stalls;
// a character updates the parser state in the cycle after it is taken into the input register.
// An end-of-string request writes its verdict to the result register when it leaves the input register.
// Synchronous reset clears the parser state and both valid flags.
// Characters keep flowing while a verdict waits; an end-of-string request
// stalls in the input register only while the result register is still held.
`default_nettype none

module exact_semver_validator (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire                     req_action,
   input  wire [esv_pkg::CH_W-1:0] req_ch,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic                    rsp_valid_res
);

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_action_ff;
   logic [esv_pkg::CH_W-1:0] s1_ch_ff;
   esv_pkg::state_type      state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_res_ff;

   logic out_free;
   logic s1_go;
   logic req_take;
   logic verdict;
   esv_pkg::state_type state_next;

   esv_step u_step (
      .state      (state_ff),
      .action     (s1_action_ff),
      .ch         (s1_ch_ff),
      .state_next (state_next),
      .verdict    (verdict)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && ((s1_action_ff == esv_pkg::ACT_CHAR) || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign state_in     = s1_go ? state_next : state_ff;
   assign rsp_valid_in = (s1_go && (s1_action_ff == esv_pkg::ACT_END)) ? 1'b1
                       : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= esv_pkg::reset_state();
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_action;
         s1_ch_ff     <= req_ch;
      end
      if (s1_go && (s1_action_ff == esv_pkg::ACT_END)) begin
         rsp_res_ff <= verdict;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && (s1_action_ff == esv_pkg::ACT_END)))
      else $error("request stalled without a pending end-of-string");

   a_end_resets_parser: assert property (@(posedge clock) disable iff (reset)
      (s1_go && (s1_action_ff == esv_pkg::ACT_END)) |=>
         ((state_ff.phase == esv_pkg::PH_MAJOR) && (state_ff.ident_length == 2'd0)
          && !state_ff.rejected && !state_ff.suffix_seen))
      else $error("parser not reset after end of string");

   a_reject_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff.rejected && !(s1_go && (s1_action_ff == esv_pkg::ACT_END))) |=>
         state_ff.rejected)
      else $error("rejection cleared before end of string");

   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && (s1_action_ff == esv_pkg::ACT_END)))
      else $error("response without end-of-string request");

endmodule

`default_nettype wire
